>>> hw/rtl/hlst_pkg.sv
// Held lock set tracker: shared types and constants.
// No dependencies; imported by hlst_cell and held_lock_set_tracker.
`default_nettype none

package hlst_pkg;

  localparam int unsigned ID_W    = 64;
  localparam int unsigned COUNT_W = 4;

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // Search token and "match seen upstream" flag passed cell to cell.
  typedef struct packed {
    logic tok;
    logic del;
  } hlst_link_t;

endpackage

`default_nettype wire

>>> hw/rtl/held_lock_set_tracker.sv
// Held lock set tracker top level: control, count, and chain of slot cells.
// Depends on hlst_pkg and hlst_cell.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o   func_i, lock_id_i
//   out      output     out_valid_o/out_stall_i held_count_o, overflowed_o, hit_o
//
// Add: slot written at accept; the result goes out through the DONE state.
// Remove: a search token walks the cell chain one slot per cycle, then the slots
// past the match all shift down by one together.
// One request in flight; the result waits in the output register under stall.
// Reset empties the set (count and overflow zero); slot contents are not cleared.
`default_nettype none

module held_lock_set_tracker #(
  parameter int unsigned CAPACITY = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      func_i,
  input  logic [hlst_pkg::ID_W-1:0] lock_id_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [hlst_pkg::COUNT_W-1:0] held_count_o,
  output logic                      overflowed_o,
  output logic                      hit_o
);
  import hlst_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic            full_q, full_d;
  logic            hit_pend_q, hit_pend_d;
  logic            start_q;
  logic [ID_W-1:0] key_q;

  logic                    out_valid_q;
  logic [COUNT_W-1:0]      held_count_q;
  logic                    overflowed_q;
  logic                    hit_q;

  logic            in_acc;
  logic            add_ok;
  logic            shift;
  logic            found;
  logic            scan_end;
  logic            out_load;
  logic [ID_W-1:0] key_bus;
  logic [CW+COUNT_W-1:0] count_ext;

  logic [ID_W-1:0] entry_w [CAPACITY];
  hlst_link_t      link_w  [CAPACITY+1];
  logic [CAPACITY-1:0] tok_vec;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign add_ok   = in_acc && (func_i == FUNC_ADD) && !full_q && (count_q < CAP_C);
  assign key_bus  = (state_q == ST_IDLE) ? lock_id_i : key_q;
  assign scan_end = (state_q == ST_SCAN) && link_w[CAPACITY].tok;
  assign found    = link_w[CAPACITY].del;
  assign shift    = scan_end && found;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  assign link_w[0] = '{tok: start_q, del: 1'b0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic [ID_W-1:0] next_entry;

    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = entry_w[i];
    end else begin : g_mid
      assign next_entry = entry_w[i+1];
    end

    hlst_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .key_i       (key_bus),
      .load_i      (add_ok && (count_q == IDX)),
      .live_i      (count_q > IDX),
      .shift_i     (shift),
      .next_entry_i(next_entry),
      .link_i      (link_w[i]),
      .link_o      (link_w[i+1]),
      .entry_o     (entry_w[i])
    );

    assign tok_vec[i] = link_w[i].tok;
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    full_d     = full_q;
    hit_pend_d = hit_pend_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (func_i == FUNC_ADD) begin
            hit_pend_d = 1'b0;
            state_d    = ST_DONE;
            if (!full_q) begin
              if (count_q < CAP_C) begin
                count_d    = count_q + 1'b1;
                hit_pend_d = 1'b1;
                full_d     = (count_q + 1'b1) == CAP_C;
              end else begin
                full_d = 1'b1;
              end
            end
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          hit_pend_d = found;
          state_d    = ST_DONE;
          if (found) begin
            count_d = count_q - 1'b1;
            full_d  = 1'b0;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      full_q      <= 1'b0;
      hit_pend_q  <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      full_q     <= full_d;
      hit_pend_q <= hit_pend_d;
      start_q    <= in_acc && (func_i == FUNC_REMOVE);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_q};

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q <= lock_id_i;
    end
    if (out_load) begin
      held_count_q <= count_ext[COUNT_W-1:0];
      overflowed_q <= full_q;
      hit_q        <= hit_pend_q;
    end
  end

  assign in_stall_o   = state_q != ST_IDLE;
  assign out_valid_o  = out_valid_q;
  assign held_count_o = held_count_q;
  assign overflowed_o = overflowed_q;
  assign hit_o        = hit_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("held count above capacity");

  a_full_means_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (count_q == CAP_C))
    else $error("overflow flag without a full table");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one search token in the chain");

  a_token_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_vec != '0) |-> (state_q == ST_SCAN))
    else $error("search token outside a remove");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("result not presented after completion");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/hlst_cell.sv
// Held lock set tracker: one table slot of the cell chain.
// Depends on hlst_pkg (ID_W, hlst_link_t).
`default_nettype none

module hlst_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [hlst_pkg::ID_W-1:0] key_i,
  input  logic                     load_i,
  input  logic                     live_i,
  input  logic                     shift_i,
  input  logic [hlst_pkg::ID_W-1:0] next_entry_i,
  input  hlst_pkg::hlst_link_t     link_i,
  output hlst_pkg::hlst_link_t     link_o,
  output logic [hlst_pkg::ID_W-1:0] entry_o
);
  import hlst_pkg::*;

  logic [ID_W-1:0] entry_q;
  logic            tok_q;
  logic            del_q, del_d;
  logic            match;

  // Compare only while the token sits here and the slot holds a live entry.
  assign match = link_i.tok && live_i && (entry_q == key_i);
  // Once a match is seen, every slot from there on closes the gap.
  assign del_d = link_i.tok ? (link_i.del | match) : del_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      entry_q <= key_i;
    end else if (shift_i && del_q) begin
      entry_q <= next_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
      del_q <= 1'b0;
    end else begin
      tok_q <= link_i.tok;
      del_q <= del_d;
    end
  end

  assign link_o.tok = tok_q;
  assign link_o.del = del_q;
  assign entry_o    = entry_q;

endmodule

`default_nettype wire
